FILE: design/m4i_pkg.sv
// Shared constants and width helpers for the 4x4 adjugate matrix inverter.
package m4i_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_ELEMS      = 16;

   // Width of a signed 3x3 cofactor built from elements of the given width.
   function automatic int cof_width(int ew);
      return 3 * ew + 3;
   endfunction

   // Width of the signed determinant accumulator.
   function automatic int det_width(int ew);
      return 4 * ew + 5;
   endfunction

   // Width of a multiplier operand split into at most four element-wide chunks.
   function automatic int opnd_width(int ew);
      return 4 * ew + 1;
   endfunction

   // Index of the n-th of the three lines that remain once line c is removed.
   function automatic logic [1:0] skip_index(logic [1:0] n, logic [1:0] c);
      return (n >= c) ? n + 2'd1 : n;
   endfunction

endpackage

FILE: design/m4i_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module m4i_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

FILE: design/m4i_mul.sv
// Shared signed multiplier: one element-wide chunk of a wide operand times one element.
module m4i_mul #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic [m4i_pkg::opnd_width(ELEM_WIDTH)-1:0]    opnd,
   input  logic [1:0]                                    chunk_sel,
   input  logic                                          chunk_last,
   input  logic [ELEM_WIDTH-1:0]                         mult_x,
   output logic signed [2*ELEM_WIDTH+1:0]                prod_ff
);
   import m4i_pkg::*;

   logic [ELEM_WIDTH:0]             chunk;
   logic signed [2*ELEM_WIDTH+1:0]  prod_in;

   // Lower chunks are unsigned; only the top chunk carries the sign.
   always_comb begin
      chunk = opnd[chunk_sel * ELEM_WIDTH +: ELEM_WIDTH + 1];
      if (!chunk_last) begin
         chunk[ELEM_WIDTH] = 1'b0;
      end
      prod_in = $signed(chunk) * $signed({mult_x[ELEM_WIDTH-1], mult_x});
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: design/m4i_div.sv
// Restoring divider: rounded, saturated cofactor-over-determinant quotient.
module m4i_div #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [m4i_pkg::cof_width(ELEM_WIDTH)-1:0]   num,
   input  logic [m4i_pkg::det_width(ELEM_WIDTH)-1:0]   den,
   output logic                                        done_ff,
   output logic [ELEM_WIDTH-1:0]                       quo
);
   import m4i_pkg::*;

   localparam int CW   = cof_width(ELEM_WIDTH);
   localparam int DW   = det_width(ELEM_WIDTH);
   localparam int RW   = 5 * ELEM_WIDTH + 2 * FRAC_BITS + 8;
   localparam int QW   = ELEM_WIDTH + 2;
   localparam int CNTW = $clog2(QW + 1);

   logic [RW-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0]   q_ff, q_in;
   logic            neg_ff, neg_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in, done_in;

   logic [CW-1:0]   num_mag;
   logic [DW-1:0]   den_mag;
   logic            ge;
   logic [QW-1:0]   lim, mag;

   always_comb begin
      num_mag = num[CW-1] ? (~num + 1'b1) : num;
      den_mag = den[DW-1] ? (~den + 1'b1) : den;
      ge      = rem_ff >= dsh_ff;

      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (start) begin
         // Rounded quotient is floor((2n + d) / 2d), with n already scaled up.
         rem_in = (RW'(num_mag) << (2 * FRAC_BITS + 1)) + RW'(den_mag);
         dsh_in = RW'(den_mag) << QW;
         q_in   = '0;
         neg_in = num[CW-1] ^ den[DW-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end

      // A set top bit means the true quotient is beyond any representable value.
      lim = neg_ff ? (QW'(1) << (ELEM_WIDTH - 1)) : ((QW'(1) << (ELEM_WIDTH - 1)) - 1'b1);
      mag = (q_ff > lim) ? lim : q_ff;
      quo = neg_ff ? ELEM_WIDTH'(~mag + 1'b1) : ELEM_WIDTH'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

endmodule

FILE: design/matrix4_inverse_adjugate_top.sv
// Top level of the 4x4 matrix inverter by adjugate and cofactor expansion.
//
// Usage: the block takes one matrix element per item on req_elem_value,
// column-major, when start is high and busy is low. Fifteen items are only
// stored. The sixteenth item sets busy and starts the computation.
// All sixteen signed 3x3 cofactors are built on one shared multiplier: each
// cofactor takes six passes for the three 2x2 determinants, three passes that
// scale them by the expansion elements, and one write, and the four cofactors
// of row 0 are folded into the determinant. Each of the sixteen results of a
// nonsingular matrix then goes through a restoring divider that settles
// one quotient bit per cycle; for a singular matrix the results follow
// one per cycle.
// Results leave column-major on rsp_inv_value, each for exactly one cycle
// with rsp_strobe high, carrying its position, a last flag and the singular
// flag. The receiver cannot hold results off. busy falls in the cycle in
// which the last result is on the ports. Reset clears the control state and
// the load count; the element store needs no clearing, since a run reads
// only what it loaded.
module matrix4_inverse_adjugate_top #(
   parameter int ELEM_WIDTH = m4i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m4i_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ELEM_WIDTH-1:0] req_elem_value,
   output logic                  busy,
   output logic                  rsp_strobe,
   output logic [ELEM_WIDTH-1:0] rsp_inv_value,
   output logic [3:0]            rsp_inv_index,
   output logic                  rsp_is_last,
   output logic                  rsp_singular
);
   import m4i_pkg::*;

   localparam int CW  = cof_width(ELEM_WIDTH);
   localparam int DW  = det_width(ELEM_WIDTH);
   localparam int AW  = opnd_width(ELEM_WIDTH);
   localparam int PW  = 2 * ELEM_WIDTH + 2;
   localparam int TW  = 2 * ELEM_WIDTH + 1;
   localparam int SHW = $clog2(3 * ELEM_WIDTH + 1);
   localparam int IW  = $clog2(NUM_ELEMS);

   typedef enum logic [7:0] {
      S_LOAD = 8'b0000_0001,
      S_RD   = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_ACC  = 8'b0000_1000,
      S_WR   = 8'b0001_0000,
      S_CRD  = 8'b0010_0000,
      S_DST  = 8'b0100_0000,
      S_DIV  = 8'b1000_0000
   } state_type;

   // Work done by one multiply pass.
   typedef enum logic [1:0] {
      PH_PAIR_A,   // first product of a 2x2 determinant
      PH_PAIR_B,   // second product, subtracted
      PH_TERM,     // expansion element times the 2x2 determinant
      PH_DET       // row-0 element times a finished cofactor
   } phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [IW-1:0]    load_cnt_ff, load_cnt_in;
   logic [IW-1:0]    kc_ff, kc_in;
   logic [IW-1:0]    out_k_ff, out_k_in;
   logic [1:0]       term_ff, term_in;
   logic [1:0]       chunk_ff, chunk_in;
   logic             sing_ff, sing_in;
   logic [TW-1:0]    tmp_ff, tmp_in;
   logic [CW-1:0]    cof_ff, cof_in;
   logic [DW-1:0]    det_ff, det_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [ELEM_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [3:0]            rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_sing_ff, rsp_sing_in;

   logic                  accept;
   logic [1:0]            col, row, c0, c1, c2, ri, ra, rb;
   logic [IW-1:0]         addr_a, addr_b;
   logic [ELEM_WIDTH-1:0] elem_a, elem_b;
   logic [AW-1:0]         opnd;
   logic [1:0]            last_chunk;
   logic                  chunk_last;
   logic signed [PW-1:0]  prod;
   logic [SHW-1:0]        shift_amt;
   logic [DW-1:0]         shifted;
   logic                  term_neg;
   logic [CW-1:0]         cof_rd;
   logic                  div_done;
   logic [ELEM_WIDTH-1:0] div_quo;
   logic                  emit;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_LOAD);

   // Element addressing for the current cofactor, term and pass.
   always_comb begin
      col = kc_ff[3:2];
      row = kc_ff[1:0];
      c0  = skip_index(2'd0, col);
      c1  = skip_index(2'd1, col);
      c2  = skip_index(2'd2, col);
      ri  = skip_index(term_ff, row);
      ra  = skip_index((term_ff == 2'd0) ? 2'd1 : 2'd0, row);
      rb  = skip_index((term_ff == 2'd2) ? 2'd1 : 2'd2, row);

      case (phase_ff)
         PH_PAIR_A: begin
            addr_a     = {c1, ra};
            addr_b     = {c2, rb};
            opnd       = {{(AW - ELEM_WIDTH){elem_a[ELEM_WIDTH-1]}}, elem_a};
            last_chunk = 2'd0;
         end
         PH_PAIR_B: begin
            addr_a     = {c1, rb};
            addr_b     = {c2, ra};
            opnd       = {{(AW - ELEM_WIDTH){elem_a[ELEM_WIDTH-1]}}, elem_a};
            last_chunk = 2'd0;
         end
         PH_TERM: begin
            addr_a     = {c1, ra};
            addr_b     = {c0, ri};
            opnd       = {{(AW - TW){tmp_ff[TW-1]}}, tmp_ff};
            last_chunk = 2'd1;
         end
         default: begin
            addr_a     = {c1, ra};
            addr_b     = {col, 2'd0};
            opnd       = {{(AW - CW){cof_ff[CW-1]}}, cof_ff};
            last_chunk = 2'd3;
         end
      endcase

      chunk_last = (chunk_ff == last_chunk);
      shift_amt  = SHW'(chunk_ff) * SHW'(ELEM_WIDTH);
      shifted    = {{(DW - PW){prod[PW-1]}}, prod} << shift_amt;
      // Expansion sign of the term times the checkerboard sign of the cofactor.
      term_neg   = term_ff[0] ^ kc_ff[2] ^ kc_ff[0];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      load_cnt_in   = load_cnt_ff;
      kc_in         = kc_ff;
      out_k_in      = out_k_ff;
      term_in       = term_ff;
      chunk_in      = chunk_ff;
      sing_in       = sing_ff;
      tmp_in        = tmp_ff;
      cof_in        = cof_ff;
      det_in        = det_ff;
      emit          = 1'b0;

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               load_cnt_in = load_cnt_ff + 1'b1;
               if (load_cnt_ff == IW'(NUM_ELEMS - 1)) begin
                  kc_in    = '0;
                  term_in  = '0;
                  chunk_in = '0;
                  phase_in = PH_PAIR_A;
                  cof_in   = '0;
                  det_in   = '0;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            case (phase_ff)
               PH_PAIR_A: tmp_in = shifted[TW-1:0];
               PH_PAIR_B: tmp_in = tmp_ff - shifted[TW-1:0];
               PH_TERM: begin
                  cof_in = term_neg ? cof_ff - shifted[CW-1:0] : cof_ff + shifted[CW-1:0];
               end
               default: det_in = det_ff + shifted;
            endcase
            if (!chunk_last) begin
               chunk_in = chunk_ff + 1'b1;
               state_in = S_MUL;
            end else begin
               chunk_in = '0;
               state_in = S_RD;
               case (phase_ff)
                  PH_PAIR_A: phase_in = PH_PAIR_B;
                  PH_PAIR_B: phase_in = PH_TERM;
                  PH_TERM: begin
                     phase_in = PH_PAIR_A;
                     if (term_ff == 2'd2) begin
                        term_in  = '0;
                        state_in = S_WR;
                     end else begin
                        term_in = term_ff + 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_PAIR_A;
                     kc_in    = kc_ff + 1'b1;
                     cof_in   = '0;
                  end
               endcase
            end
         end
         S_WR: begin
            if (row == 2'd0) begin
               // Fold this cofactor into the determinant before moving on.
               phase_in = PH_DET;
               state_in = S_RD;
            end else if (kc_ff == IW'(NUM_ELEMS - 1)) begin
               sing_in  = (det_ff == '0);
               out_k_in = '0;
               state_in = S_CRD;
            end else begin
               kc_in    = kc_ff + 1'b1;
               cof_in   = '0;
               state_in = S_RD;
            end
         end
         S_CRD: begin
            if (sing_ff) begin
               emit = 1'b1;
               out_k_in = out_k_ff + 1'b1;
               state_in = (out_k_ff == IW'(NUM_ELEMS - 1)) ? S_LOAD : S_CRD;
            end else begin
               state_in = S_DST;
            end
         end
         S_DST: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               emit = 1'b1;
               out_k_in = out_k_ff + 1'b1;
               state_in = (out_k_ff == IW'(NUM_ELEMS - 1)) ? S_LOAD : S_CRD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      rsp_strobe_in = emit;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_sing_in   = rsp_sing_ff;
      if (emit) begin
         rsp_value_in = sing_ff ? '0 : div_quo;
         rsp_index_in = out_k_ff;
         rsp_last_in  = (out_k_ff == IW'(NUM_ELEMS - 1));
         rsp_sing_in  = sing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         load_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_cnt_ff   <= load_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      kc_ff        <= kc_in;
      out_k_ff     <= out_k_in;
      term_ff      <= term_in;
      chunk_ff     <= chunk_in;
      sing_ff      <= sing_in;
      tmp_ff       <= tmp_in;
      cof_ff       <= cof_in;
      det_ff       <= det_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sing_ff  <= rsp_sing_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_inv_value = rsp_value_ff;
   assign rsp_inv_index = rsp_index_ff;
   assign rsp_is_last   = rsp_last_ff;
   assign rsp_singular  = rsp_sing_ff;

   // Two copies of the element store give two read ports.
   m4i_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(NUM_ELEMS)) u_elem_a (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (load_cnt_ff),
      .wr_data    (req_elem_value),
      .rd_addr    (addr_a),
      .rd_data_ff (elem_a)
   );

   m4i_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(NUM_ELEMS)) u_elem_b (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (load_cnt_ff),
      .wr_data    (req_elem_value),
      .rd_addr    (addr_b),
      .rd_data_ff (elem_b)
   );

   // Cofactors are read back transposed: result (col,row) uses C(row,col).
   m4i_ram #(.WIDTH(CW), .DEPTH(NUM_ELEMS)) u_cof (
      .clock      (clock),
      .wr_en      (state_ff == S_WR),
      .wr_addr    (kc_ff),
      .wr_data    (cof_ff),
      .rd_addr    ({out_k_ff[1:0], out_k_ff[3:2]}),
      .rd_data_ff (cof_rd)
   );

   m4i_mul #(.ELEM_WIDTH(ELEM_WIDTH)) u_mul (
      .clock      (clock),
      .opnd       (opnd),
      .chunk_sel  (chunk_ff),
      .chunk_last (chunk_last),
      .mult_x     (elem_b),
      .prod_ff    (prod)
   );

   m4i_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_DST),
      .num     (cof_rd),
      .den     (det_ff),
      .done_ff (div_done),
      .quo     (div_quo)
   );

   // The sixteenth item always starts a computation.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && load_cnt_ff == IW'(NUM_ELEMS - 1)) |=> busy)
      else $error("last element did not start a computation");

   // The last flag marks exactly the final position.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_last == (rsp_inv_index == 4'd15)))
      else $error("last flag does not match result position");

   // A singular matrix gives zero values.
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_singular) |-> (rsp_inv_value == '0))
      else $error("singular result carries a nonzero value");

   // The divider only finishes while the sequencer waits for it.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside its wait state");

endmodule
